// ===== design/noc_ovc_pkg.sv =====
// Shared constants for the router output virtual-channel block.
`timescale 1ns / 1ps

package noc_ovc_pkg;

    localparam int DEF_NUM_PORTS    = 5;
    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_FLIT_BITS    = 32;

    localparam int PORT_W   = 3;
    localparam int VC_W     = 2;
    localparam int DATA_W   = 32;
    localparam int CREDIT_W = 4;
    localparam int READY_W  = 5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_FLIT = 1'b1;

endpackage

// ===== design/noc_output_vc_channel.sv =====
// Router output port with per-port holding registers, per-VC registers and credit flow.
`timescale 1ns / 1ps
//
// Input stream (s_axis): one transfer per item. tuser selects the kind: a clock
// tick serves the VC under the round-robin pointer and then moves held flits
// into free VCs, lowest port first; a flit arrival enters its VC register or,
// if that VC is busy, the holding register of its port.
// Output stream (m_axis): exactly one transfer per input transfer, in order.
// tuser is set when a flit departs; tdata carries its VC and data (zero when
// none departs) and the ready bits of ports 0 to 4 after the item.
// Configuration: cfg_wr_en writes cfg_wr_data into the local-port flag, which
// skips the credit check; write it only while the block is idle.
// Output: results are registered; all state updates in the accepting cycle.
// Throughput: one item per cycle while s_axis_tready is high.
// A two-entry output buffer lets an input transfer complete while a result is
// still waiting, so s_axis_tready drops only when both entries are full.
// Reset (aresetn low, synchronous): all holding and VC registers empty, serve
// pointer at zero, all port ready bits set, local-port flag clear, no output.
//
module noc_output_vc_channel #(
    parameter int NUM_PORTS    = noc_ovc_pkg::DEF_NUM_PORTS,
    parameter int NUM_CHANNELS = noc_ovc_pkg::DEF_NUM_CHANNELS,
    parameter int FLIT_BITS    = noc_ovc_pkg::DEF_FLIT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // port[2:0], flit_vc[4:3], flit_data[36:5], credit_free[40:37], zero pad
    input  logic [noc_ovc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_vc[1:0], out_data[33:2], ready_mask[38:34], zero pad
    output logic [noc_ovc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // out_valid[0]
    output logic                                m_axis_tuser
);
    import noc_ovc_pkg::*;

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FLIT_W  = (FLIT_BITS < DATA_W) ? FLIT_BITS : DATA_W;
    localparam int RDY_EXT = (NUM_PORTS > READY_W) ? NUM_PORTS : READY_W;

    logic [PORT_W-1:0]   in_port;
    logic [VC_W-1:0]     in_vc;
    logic [FLIT_W-1:0]   in_data;
    logic [CREDIT_W-1:0] in_credit;

    logic                local_reg;
    logic [NUM_PORTS-1:0]    held_valid_reg, held_valid_next;
    logic [VC_W-1:0]         held_vc_reg    [NUM_PORTS];
    logic [VC_W-1:0]         held_vc_next   [NUM_PORTS];
    logic [FLIT_W-1:0]       held_flit_reg  [NUM_PORTS];
    logic [FLIT_W-1:0]       held_flit_next [NUM_PORTS];
    logic [NUM_CHANNELS-1:0] vc_valid_reg, vc_valid_next;
    logic [FLIT_W-1:0]       vc_flit_reg  [NUM_CHANNELS];
    logic [FLIT_W-1:0]       vc_flit_next [NUM_CHANNELS];
    logic [CH_W-1:0]         ptr_reg, ptr_next;
    logic [NUM_PORTS-1:0]    ready_reg, ready_next;

    logic                sent;
    logic [VC_W-1:0]     sent_vc;
    logic [FLIT_W-1:0]   sent_data;
    logic                room;
    logic                found;
    logic [RDY_EXT-1:0]  ready_wide;
    logic [M_TDATA_W-1:0] res_data;

    logic                 out_valid_reg, skid_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, skid_data_reg;
    logic                 out_user_reg, skid_user_reg;
    logic                 in_fire, out_fire;

    assign in_port   = s_axis_tdata[2:0];
    assign in_vc     = s_axis_tdata[4:3];
    assign in_data   = s_axis_tdata[5 +: FLIT_W];
    assign in_credit = s_axis_tdata[40:37];

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;

    always_comb begin
        held_valid_next = held_valid_reg;
        held_vc_next    = held_vc_reg;
        held_flit_next  = held_flit_reg;
        vc_valid_next   = vc_valid_reg;
        vc_flit_next    = vc_flit_reg;
        ptr_next        = ptr_reg;
        ready_next      = ready_reg;
        sent            = 1'b0;
        sent_vc         = '0;
        sent_data       = '0;
        room            = 1'b0;
        found           = 1'b0;
        if (s_axis_tuser == KIND_TICK) begin
            for (int k = 0; k < CREDIT_W; k++) begin
                if (k < NUM_CHANNELS && ptr_reg == CH_W'(k)) begin
                    room = in_credit[k];
                end
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (ptr_reg == CH_W'(c) && vc_valid_reg[c] && (local_reg || room)) begin
                    sent             = 1'b1;
                    sent_vc          = VC_W'(c);
                    sent_data        = vc_flit_reg[c];
                    vc_valid_next[c] = 1'b0;
                end
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                found = 1'b0;
                if (c < (1 << VC_W) && !vc_valid_next[c]) begin
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        if (!found && held_valid_reg[p] && held_vc_reg[p] == VC_W'(c)) begin
                            found              = 1'b1;
                            vc_valid_next[c]   = 1'b1;
                            vc_flit_next[c]    = held_flit_reg[p];
                            held_valid_next[p] = 1'b0;
                            ready_next[p]      = 1'b1;
                        end
                    end
                end
            end
            if (ptr_reg == CH_W'(NUM_CHANNELS - 1)) begin
                ptr_next = '0;
            end else begin
                ptr_next = ptr_reg + 1'b1;
            end
        end else begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (p < (1 << PORT_W) && c < (1 << VC_W) &&
                        in_port == PORT_W'(p) && in_vc == VC_W'(c)) begin
                        if (vc_valid_reg[c]) begin
                            held_vc_next[p]    = in_vc;
                            held_flit_next[p]  = in_data;
                            held_valid_next[p] = 1'b1;
                            ready_next[p]      = 1'b0;
                        end else begin
                            vc_flit_next[c]    = in_data;
                            vc_valid_next[c]   = 1'b1;
                            held_valid_next[p] = 1'b0;
                            ready_next[p]      = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign ready_wide = RDY_EXT'(ready_next);
    assign res_data   = M_TDATA_W'({ready_wide[READY_W-1:0], DATA_W'(sent_data), sent_vc});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_reg      <= 1'b0;
            held_valid_reg <= '0;
            vc_valid_reg   <= '0;
            ptr_reg        <= '0;
            ready_reg      <= '1;
        end else begin
            if (cfg_wr_en) begin
                local_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                held_valid_reg <= held_valid_next;
                vc_valid_reg   <= vc_valid_next;
                ptr_reg        <= ptr_next;
                ready_reg      <= ready_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            held_vc_reg   <= held_vc_next;
            held_flit_reg <= held_flit_next;
            vc_flit_reg   <= vc_flit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_fire) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_fire) begin
                if (out_valid_reg && !out_fire) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !out_fire) begin
                skid_data_reg <= res_data;
                skid_user_reg <= sent;
            end else begin
                out_data_reg <= res_data;
                out_user_reg <= sent;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
